/* sv/amx_pkg.sv */
`default_nettype none
package amx_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ENTRY_WIDTH = 24;

  localparam int EW  = ENTRY_WIDTH;
  localparam int FB  = FRAC_BITS;
  // Exact 2x2 minor and 3x3 determinant widths.
  localparam int MW  = 2 * EW + 1;
  localparam int DW  = 3 * EW + 3;
  localparam int THW = EW - 1;
  // Divider numerator and remainder widths.
  localparam int NW0 = (MW + 2 * FB > DW) ? MW + 2 * FB : DW;
  localparam int NW  = NW0 + 1;
  localparam int RW  = (NW > DW + EW) ? NW : DW + EW;
  localparam int AW  = 2 * EW + 2;
  localparam int TW  = 2 * EW + 3;
  localparam int KW  = $clog2(EW);

  localparam int IN_DW  = ((12 * EW + 7) / 8) * 8;
  localparam int OUT_FW = 2 + 3 * EW;
  localparam int OUT_DW = ((OUT_FW + 7) / 8) * 8;

  localparam logic [EW-1:0] EMAX    = {1'b0, {(EW-1){1'b1}}};
  localparam logic [EW-1:0] EMIN    = {1'b1, {(EW-1){1'b0}}};
  localparam logic [EW-1:0] ONE_VAL = (FB <= EW - 2) ? (EW'(1) << FB) : EMAX;

  typedef struct packed {
    logic [8:0][MW-1:0] cof;
    logic [DW-1:0]      det;
    logic [2:0][EW-1:0] t;
    logic               sing;
  } amx_job_t;

endpackage
`default_nettype wire

/* sv/affine_matrix_inverse_top.sv */
// Channel   Direction  Word contents (lowest bits first)
// in_       slave      a11 a12 a13 a21 a22 a23 a31 a32 a33 tx ty tz
// out_      master     row_index col_one col_two col_three; tuser singular; tlast last_row
// cfg_      write      det_threshold
//
// The front works through nine minors, three determinant terms and a hand-off per matrix,
// and accepts no new word until the queue has taken that hand-off.
// The back runs nine divisions in turn through one shared restoring divider, then works
// out the translation row, and takes no new matrix until the last one is handed on.
// A singular matrix skips both; four rows then leave at one per cycle while out_tready is high.
// Reset is synchronous and active low; a two-deep queue parts front and back.
`default_nettype none
module affine_matrix_inverse_top import amx_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_tvalid,
  output logic              in_tready,
  input  wire [IN_DW-1:0]   in_tdata,   // a11 a12 a13 a21 a22 a23 a31 a32 a33 tx ty tz
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // row_index col_one col_two col_three
  output logic              out_tlast,
  output logic              out_tuser,  // singular
  input  wire               cfg_wr_en,
  input  wire [THW-1:0]     cfg_wr_data
);

  logic [THW-1:0] thr_r;
  amx_job_t       f_job, b_job;
  logic           f_valid, f_ready, b_valid, b_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= THW'(1);
    else if (cfg_wr_en) thr_r <= cfg_wr_data;
  end

  amx_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .thr(thr_r),
    .job_valid(f_valid), .job_ready(f_ready), .job(f_job)
  );

  amx_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(f_job),
    .pop_valid(b_valid), .pop_ready(b_ready), .pop_data(b_job)
  );

  amx_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

endmodule
`default_nettype wire

/* sv/amx_front.sv */
`default_nettype none
module amx_front import amx_pkg::*; (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire [IN_DW-1:0]  in_tdata,
  input  wire [THW-1:0]    thr,
  output logic             job_valid,
  input  wire              job_ready,
  output amx_job_t         job
);

  localparam logic [3:0] ST_DET0 = 4'd9;
  localparam logic [3:0] ST_DET2 = 4'd11;
  localparam logic [3:0] ST_PUSH = 4'd12;

  logic                 busy_r;
  logic [3:0]           step_r;
  logic signed [EW-1:0] a_r [9];
  logic [2:0][EW-1:0]   t_r;
  logic signed [MW-1:0] cof_r [9];
  logic signed [DW-1:0] det_r;

  logic [3:0] ip, iq, ir, is, ic;
  logic [3:0] id;
  logic signed [2*EW-1:0] mul1, mul2, ph;
  logic signed [2*EW+1:0] pl;
  logic signed [MW-1:0]   cof_val, csel;
  logic signed [DW-1:0]   term;
  logic [DW-1:0]          dm;
  logic [8:0][MW-1:0]     cof_pack;

  always_comb begin
    ip = 4'd0; iq = 4'd0; ir = 4'd0; is = 4'd0; id = 4'd0; ic = 4'd0;
    case (step_r)
      4'd0: begin ip = 4'd4; iq = 4'd8; ir = 4'd5; is = 4'd7; end
      4'd1: begin ip = 4'd2; iq = 4'd7; ir = 4'd1; is = 4'd8; end
      4'd2: begin ip = 4'd1; iq = 4'd5; ir = 4'd2; is = 4'd4; end
      4'd3: begin ip = 4'd5; iq = 4'd6; ir = 4'd3; is = 4'd8; end
      4'd4: begin ip = 4'd0; iq = 4'd8; ir = 4'd2; is = 4'd6; end
      4'd5: begin ip = 4'd2; iq = 4'd3; ir = 4'd0; is = 4'd5; end
      4'd6: begin ip = 4'd3; iq = 4'd7; ir = 4'd4; is = 4'd6; end
      4'd7: begin ip = 4'd1; iq = 4'd6; ir = 4'd0; is = 4'd7; end
      4'd8: begin ip = 4'd0; iq = 4'd4; ir = 4'd1; is = 4'd3; end
      4'd9: begin id = 4'd0; ic = 4'd0; end
      4'd10: begin id = 4'd1; ic = 4'd3; end
      4'd11: begin id = 4'd2; ic = 4'd6; end
      default: ;
    endcase
  end

  assign mul1    = a_r[ip] * a_r[iq];
  assign mul2    = a_r[ir] * a_r[is];
  assign cof_val = MW'(mul1) - MW'(mul2);

  // The minor is split so that each product stays near entry by entry width.
  assign csel = cof_r[ic];
  assign ph   = a_r[id] * $signed(csel[MW-1:EW+1]);
  assign pl   = a_r[id] * $signed({1'b0, csel[EW:0]});
  assign term = (DW'(ph) <<< (EW + 1)) + DW'(pl);

  assign dm = det_r[DW-1] ? (~det_r + 1'b1) : det_r;

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      cof_pack[k] = cof_r[k];
    end
  end

  assign in_tready = !busy_r;
  assign job_valid = busy_r && (step_r == ST_PUSH);
  assign job.cof   = cof_pack;
  assign job.det   = det_r;
  assign job.t     = t_r;
  assign job.sing  = (dm == '0) || (RW'(dm) < (RW'(thr) << (2 * FB)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 4'd0;
    end else if (!busy_r) begin
      if (in_tvalid) begin
        busy_r <= 1'b1;
        step_r <= 4'd0;
      end
    end else if (step_r == ST_PUSH) begin
      if (job_ready) begin
        busy_r <= 1'b0;
      end
    end else begin
      step_r <= step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && in_tvalid) begin
      for (int k = 0; k < 9; k++) begin
        a_r[k] <= in_tdata[k*EW +: EW];
      end
      for (int m = 0; m < 3; m++) begin
        t_r[m] <= in_tdata[(9+m)*EW +: EW];
      end
    end
    if (busy_r && step_r < ST_DET0) begin
      cof_r[step_r] <= cof_val;
    end
    if (busy_r && step_r == ST_DET0) begin
      det_r <= term;
    end else if (busy_r && step_r > ST_DET0 && step_r <= ST_DET2) begin
      det_r <= det_r + term;
    end
  end

endmodule
`default_nettype wire

/* sv/amx_queue.sv */
`default_nettype none
module amx_queue import amx_pkg::*; (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      push_valid,
  output logic     push_ready,
  input  amx_job_t push_data,
  output logic     pop_valid,
  input  wire      pop_ready,
  output amx_job_t pop_data
);

  amx_job_t   mem [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= !wr_ptr_r;
      if (do_pop) rd_ptr_r <= !rd_ptr_r;
      if (do_push && !do_pop) cnt_r <= cnt_r + 2'd1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 2'd1;
    end
  end

endmodule
`default_nettype wire

/* sv/amx_back.sv */
`default_nettype none
module amx_back import amx_pkg::*; (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               job_valid,
  output logic              job_ready,
  input  amx_job_t          job,
  output logic              out_tvalid,
  input  wire               out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic              out_tlast,
  output logic              out_tuser
);

  typedef enum logic [6:0] {
    B_IDLE  = 7'b0000001,
    B_DINIT = 7'b0000010,
    B_DITER = 7'b0000100,
    B_DFIN  = 7'b0001000,
    B_TRN   = 7'b0010000,
    B_TFIN  = 7'b0100000,
    B_HAND  = 7'b1000000
  } bstate_t;

  bstate_t state_r, state_nxt;

  amx_job_t       job_r;
  logic [DW-1:0]  dm_r;
  logic           det_neg_r;
  logic [EW-1:0]  res_r [12];
  logic [3:0]     e_r;
  logic [KW-1:0]  k_r;
  logic [RW-1:0]  rem_r, dsh_r;
  logic [EW-1:0]  q_r;
  logic           ovf_r, cneg_r;
  logic [1:0]     j_r, m_r;
  logic signed [AW-1:0] acc_r;

  logic [EW-1:0]  em_rows_r [12];
  logic           em_sing_r, em_busy_r;
  logic [1:0]     row_r;

  logic [DW-1:0]  in_dm;
  logic [MW-1:0]  cof, cm;
  logic [RW-1:0]  numer;
  logic [EW-1:0]  qfin;
  logic [3:0]     tidx;
  logic signed [2*EW-1:0] prod;
  logic signed [TW-1:0]   tv, tsh;
  logic [EW-1:0]  tfin;

  assign in_dm = job.det[DW-1] ? (~job.det + 1'b1) : job.det;
  assign cof   = job_r.cof[e_r];
  assign cm    = cof[MW-1] ? (~cof + 1'b1) : cof;
  // Rounded quotient: the half divisor is added ahead of the division.
  assign numer = (RW'(cm) << (2 * FB)) + RW'(dm_r >> 1);

  always_comb begin
    if (ovf_r) begin
      qfin = cneg_r ? EMIN : EMAX;
    end else if (cneg_r) begin
      qfin = (q_r > EMIN) ? EMIN : (~q_r + 1'b1);
    end else begin
      qfin = (q_r > EMAX) ? EMAX : q_r;
    end
  end

  assign tidx = 4'(m_r) * 4'd3 + 4'(j_r);
  assign prod = $signed(job_r.t[m_r]) * $signed(res_r[tidx]);
  assign tv   = -TW'(acc_r) + (TW'(1) << (FB - 1));
  assign tsh  = tv >>> FB;

  always_comb begin
    if (tsh > $signed(TW'(EMAX))) tfin = EMAX;
    else if (tsh < $signed(TW'($signed(EMIN)))) tfin = EMIN;
    else tfin = tsh[EW-1:0];
  end

  assign job_ready = (state_r == B_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:  if (job_valid) state_nxt = job.sing ? B_HAND : B_DINIT;
      B_DINIT: state_nxt = B_DITER;
      B_DITER: if (k_r == '0) state_nxt = B_DFIN;
      B_DFIN:  state_nxt = (e_r == 4'd8) ? B_TRN : B_DINIT;
      B_TRN:   if (m_r == 2'd2) state_nxt = B_TFIN;
      B_TFIN:  state_nxt = (j_r == 2'd2) ? B_HAND : B_TRN;
      B_HAND:  if (!em_busy_r) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= B_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (job_valid) begin
          job_r     <= job;
          dm_r      <= in_dm;
          det_neg_r <= job.det[DW-1];
          e_r       <= 4'd0;
          for (int k = 0; k < 12; k++) begin
            res_r[k] <= (k == 0 || k == 4 || k == 8) ? ONE_VAL : '0;
          end
        end
      end
      B_DINIT: begin
        rem_r  <= numer;
        ovf_r  <= (numer >= (RW'(dm_r) << EW));
        dsh_r  <= RW'(dm_r) << (EW - 1);
        k_r    <= KW'(EW - 1);
        q_r    <= '0;
        cneg_r <= (cof[MW-1] != det_neg_r);
      end
      B_DITER: begin
        if (rem_r >= dsh_r) begin
          rem_r <= rem_r - dsh_r;
          q_r   <= {q_r[EW-2:0], 1'b1};
        end else begin
          q_r   <= {q_r[EW-2:0], 1'b0};
        end
        dsh_r <= dsh_r >> 1;
        k_r   <= k_r - 1'b1;
      end
      B_DFIN: begin
        res_r[e_r] <= qfin;
        e_r        <= e_r + 4'd1;
        j_r        <= 2'd0;
        m_r        <= 2'd0;
        acc_r      <= '0;
      end
      B_TRN: begin
        acc_r <= acc_r + AW'(prod);
        m_r   <= m_r + 2'd1;
      end
      B_TFIN: begin
        res_r[4'd9 + 4'(j_r)] <= tfin;
        j_r   <= j_r + 2'd1;
        m_r   <= 2'd0;
        acc_r <= '0;
      end
      default: ;
    endcase
  end

  // Result buffer: the next matrix can be worked on while these rows drain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_busy_r <= 1'b0;
      row_r     <= 2'd0;
    end else if (state_r == B_HAND && !em_busy_r) begin
      em_busy_r <= 1'b1;
      row_r     <= 2'd0;
    end else if (em_busy_r && out_tready) begin
      if (row_r == 2'd3) em_busy_r <= 1'b0;
      row_r <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == B_HAND && !em_busy_r) begin
      em_rows_r <= res_r;
      em_sing_r <= job_r.sing;
    end
  end

  assign out_tvalid = em_busy_r;
  assign out_tlast  = (row_r == 2'd3);
  assign out_tuser  = em_sing_r;
  assign out_tdata  = OUT_DW'({em_rows_r[4'(row_r) * 4'd3 + 4'd2],
                               em_rows_r[4'(row_r) * 4'd3 + 4'd1],
                               em_rows_r[4'(row_r) * 4'd3], row_r});

endmodule
`default_nettype wire

/* sv/amx_checker.sv */
`default_nettype none
module amx_checker import amx_pkg::*; (
  input wire              clk,
  input wire              rst_n,
  input wire              out_tvalid,
  input wire              out_tready,
  input wire [OUT_DW-1:0] out_tdata,
  input wire              out_tlast,
  input wire              out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word dropped or changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[1:0] == 2'd3)))
    else $error("last marker not on the fourth row");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=>
      out_tvalid && (out_tdata[1:0] == $past(out_tdata[1:0]) + 2'd1)
      && (out_tuser == $past(out_tuser)))
    else $error("rows of one matrix out of order");

  a_sing: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tlast |-> (out_tdata[OUT_FW-1:2] == '0))
    else $error("singular result with non-zero translation row");

endmodule

bind affine_matrix_inverse_top amx_checker u_amx_checker (.*);
`default_nettype wire

/* test/affine_matrix_inverse_top_tb.sv */
`timescale 1ns / 1ps
`default_nettype none
module affine_matrix_inverse_top_tb;
  import amx_pkg::*;

  typedef struct {
    logic [1:0]    row;
    logic [EW-1:0] c1, c2, c3;
    logic          sing;
    logic          last;
  } row_word_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_DW-1:0] out_tdata;
  logic              out_tlast;
  logic              out_tuser;
  logic              cfg_wr_en = 1'b0;
  logic [THW-1:0]    cfg_wr_data = '0;

  int errors = 0;
  int idle_cycles = 0;
  int stall_mode = 0;

  always #4 clk = ~clk;

  affine_matrix_inverse_top DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  task automatic report(input string what, input logic [127:0] got, input logic [127:0] want);
    errors++;
    $display("MISMATCH %s: got %h, expected %h", what, got, want);
  endtask

  class inverse_board;
    row_word_t expected_rows[$];
    logic [THW-1:0] threshold = THW'(1);

    function automatic logic signed [EW-1:0] sat(input logic signed [199:0] v);
      if (v > 200'sd8388607) return EMAX;
      if (v < -200'sd8388608) return EMIN;
      return v[EW-1:0];
    endfunction

    function automatic logic signed [EW-1:0] div_entry(input logic signed [199:0] cof,
                                                       input logic signed [199:0] det);
      logic [199:0] cm, dm, q;
      cm = cof < 0 ? -cof : cof;
      dm = det < 0 ? -det : det;
      q = ((cm << (2 * FB)) + (dm >> 1)) / dm;
      if ((cof < 0) != (det < 0)) return sat(-$signed(q));
      return sat($signed(q));
    endfunction

    function void note_matrix(input logic [IN_DW-1:0] w);
      logic signed [199:0] a[3][3], t[3], c[3][3], det, dm, s;
      logic signed [EW-1:0] r[4][3];
      logic sing;
      row_word_t e;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) a[i][j] = $signed(w[(i*3+j)*EW +: EW]);
      for (int j = 0; j < 3; j++) t[j] = $signed(w[(9+j)*EW +: EW]);
      c[0][0] = a[1][1]*a[2][2] - a[1][2]*a[2][1];
      c[0][1] = a[0][2]*a[2][1] - a[0][1]*a[2][2];
      c[0][2] = a[0][1]*a[1][2] - a[0][2]*a[1][1];
      c[1][0] = a[1][2]*a[2][0] - a[1][0]*a[2][2];
      c[1][1] = a[0][0]*a[2][2] - a[0][2]*a[2][0];
      c[1][2] = a[0][2]*a[1][0] - a[0][0]*a[1][2];
      c[2][0] = a[1][0]*a[2][1] - a[1][1]*a[2][0];
      c[2][1] = a[0][1]*a[2][0] - a[0][0]*a[2][1];
      c[2][2] = a[0][0]*a[1][1] - a[0][1]*a[1][0];
      det = a[0][0]*c[0][0] + a[0][1]*c[1][0] + a[0][2]*c[2][0];
      dm = det < 0 ? -det : det;
      sing = (dm == 0) || (dm < ($signed({1'b0, threshold}) <<< (2 * FB)));
      if (sing) begin
        for (int i = 0; i < 4; i++)
          for (int j = 0; j < 3; j++) r[i][j] = (i == j) ? ONE_VAL : '0;
      end else begin
        for (int i = 0; i < 3; i++)
          for (int j = 0; j < 3; j++) r[i][j] = div_entry(c[i][j], det);
        for (int j = 0; j < 3; j++) begin
          s = t[0]*r[0][j] + t[1]*r[1][j] + t[2]*r[2][j];
          s = -s + (200'sd1 <<< (FB - 1));
          r[3][j] = sat(s >>> FB);
        end
      end
      for (int i = 0; i < 4; i++) begin
        e.row = 2'(i); e.c1 = r[i][0]; e.c2 = r[i][1]; e.c3 = r[i][2];
        e.sing = sing; e.last = (i == 3);
        expected_rows.push_back(e);
      end
    endfunction

    task check_row(input logic [OUT_DW-1:0] d, input logic u, input logic l);
      row_word_t e;
      if (expected_rows.size() == 0) begin
        report("unexpected word", 128'(d), '0);
        return;
      end
      e = expected_rows.pop_front();
      if (d[1:0] !== e.row) report("row_index", 128'(d[1:0]), 128'(e.row));
      if (d[2 +: EW] !== e.c1) report("col_one", 128'(d[2 +: EW]), 128'(e.c1));
      if (d[2+EW +: EW] !== e.c2) report("col_two", 128'(d[2+EW +: EW]), 128'(e.c2));
      if (d[2+2*EW +: EW] !== e.c3)
        report("col_three", 128'(d[2+2*EW +: EW]), 128'(e.c3));
      if (u !== e.sing) report("singular", 128'(u), 128'(e.sing));
      if (l !== e.last) report("last_row", 128'(l), 128'(e.last));
    endtask
  endclass

  inverse_board board = new();

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_row(out_tdata, out_tuser, out_tlast);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stall pattern; mode changes between phases.
  always @(posedge clk) begin
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  task automatic send_matrix(input logic [IN_DW-1:0] w);
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    board.note_matrix(w);
  endtask

  task automatic pause_gap();
    int g;
    g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 30) : 0;
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.expected_rows.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [THW-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.threshold = v;
  endtask

  function automatic logic [IN_DW-1:0] pack(input logic [EW-1:0] v[12]);
    logic [IN_DW-1:0] w;
    w = '0;
    for (int k = 0; k < 12; k++) w[k*EW +: EW] = v[k];
    return w;
  endfunction

  function automatic logic [EW-1:0] rand_entry();
    case ($urandom_range(0, 5))
      0: return EW'($urandom);
      1: return $urandom_range(0, 1) ? EMAX : EMIN;
      2: return EW'($signed($urandom_range(0, 8)) - 4) << FB;
      default: return EW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  // Mostly well-scaled matrices, so the regular path is exercised, with some noise.
  function automatic logic [IN_DW-1:0] rand_matrix();
    logic [EW-1:0] v[12];
    int scale;
    scale = $urandom_range(0, 3);
    for (int k = 0; k < 12; k++) begin
      if (scale == 0) v[k] = EW'($urandom);
      else if (k < 9) v[k] = (((k % 4) == 0) ? (EW'(1) << FB) : '0) +
                             EW'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
      else v[k] = rand_entry();
    end
    return pack(v);
  endfunction

  task automatic random_phase(input int n);
    for (int k = 0; k < n; k++) begin
      send_matrix(rand_matrix());
      pause_gap();
    end
    drain();
  endtask

  initial begin
    logic [EW-1:0] v[12];
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, scaled, translated, all-zero, extremes, near-singular.
    foreach (v[k]) v[k] = '0;
    send_matrix(pack(v));
    v[0] = EW'(1) << FB; v[4] = EW'(1) << FB; v[8] = EW'(1) << FB;
    send_matrix(pack(v));
    v[9] = EMAX; v[10] = EMIN; v[11] = EW'(3) << FB;
    send_matrix(pack(v));
    v[0] = EW'(2) << FB; v[4] = -(EW'(4) << FB); v[8] = EW'(1) << (FB - 2);
    send_matrix(pack(v));
    foreach (v[k]) v[k] = EMAX;
    send_matrix(pack(v));
    foreach (v[k]) v[k] = (k % 2) ? EMIN : EMAX;
    send_matrix(pack(v));
    foreach (v[k]) v[k] = '0;
    v[0] = EMIN; v[4] = EMIN; v[8] = EMIN; v[9] = EMAX; v[10] = EMAX; v[11] = EMIN;
    send_matrix(pack(v));
    v[0] = EW'(1); v[4] = EW'(1); v[8] = EW'(1);
    send_matrix(pack(v));
    v[0] = 24'hFF; v[4] = 24'h100; v[8] = 24'h101;
    send_matrix(pack(v));
    foreach (v[k]) v[k] = 24'hFFFFFF;
    send_matrix(pack(v));
    foreach (v[k]) v[k] = EW'($urandom);
    send_matrix(pack(v));
    drain();

    write_threshold('0);
    foreach (v[k]) v[k] = '0;
    send_matrix(pack(v));
    v[0] = EW'(1); v[4] = EW'(1); v[8] = EW'(1);
    send_matrix(pack(v));
    stall_mode = 1;
    random_phase(40);

    write_threshold({THW{1'b1}});
    stall_mode = 2;
    foreach (v[k]) v[k] = EMAX;
    v[1] = '0; v[2] = '0; v[3] = '0; v[5] = '0; v[6] = '0; v[7] = '0;
    send_matrix(pack(v));
    random_phase(15);

    write_threshold(THW'(1) << FB);
    stall_mode = 0;
    random_phase(40);

    write_threshold(THW'($urandom_range(1, 255)));
    stall_mode = 1;
    random_phase(50);

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
